FILE: design/fnlf_pkg.sv
// Shared types and constants for the first neighbour link finder.
// Depends on nothing; used by every module in the design folder.
package fnlf_pkg;

    localparam int COORD_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_IDX_W = 5;
    localparam int MAXPT_W  = 6;
    localparam int LIM_W    = 2 * COORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LINK_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_DISTANCE = 2'd2;

    localparam logic [OUT_IDX_W-1:0] RESULT_LIMIT = 5'd31;

    localparam logic [MAXPT_W-1:0]    MAX_POINTS_RST  = 6'd32;
    localparam logic [COORD_W-1:0]    CONNECT_DIST_RST = 16'd100;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    // compare request into the distance pipe
    typedef struct packed {
        logic valid;
        logic last;
    } t_dist_ctl;

    // compare outcome from the distance pipe
    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } t_dist_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REWIND,
        ST_LAST
    } t_state;

endpackage

FILE: design/fnlf_cell.sv
// One storage cell of the point ring: holds a single 3D point.
// Depends on fnlf_pkg.
module fnlf_cell (
    input  logic             i_clk,
    input  logic             i_load,
    input  fnlf_pkg::t_point i_load_pt,
    input  logic             i_shift,
    input  fnlf_pkg::t_point i_next_pt,
    output fnlf_pkg::t_point o_pt
);
    import fnlf_pkg::*;

    t_point r_pt;

    // load and shift never coincide: loads happen only when idle
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pt <= i_load_pt;
        end else if (i_shift) begin
            r_pt <= i_next_pt;
        end
    end

    assign o_pt = r_pt;

endmodule

FILE: design/fnlf_dist.sv
// Three-stage squared distance compare: |d| per axis, squares, sum vs limit.
// Depends on fnlf_pkg.
module fnlf_dist #(
    parameter int IW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_flush,
    input  fnlf_pkg::t_dist_ctl           i_req,
    input  logic [IW-1:0]                 i_b,
    input  fnlf_pkg::t_point              i_a_pt,
    input  fnlf_pkg::t_point              i_b_pt,
    input  logic [fnlf_pkg::LIM_W-1:0]    i_lim,
    output fnlf_pkg::t_dist_rsp           o_rsp,
    output logic [IW-1:0]                 o_b
);
    import fnlf_pkg::*;

    localparam int DW = COORD_W + 1;

    // stage 1: absolute differences
    t_dist_ctl          r_s1_ctl;
    logic [IW-1:0]      r_s1_b;
    logic [COORD_W-1:0] r_s1_dx, r_s1_dy, r_s1_dz;
    // stage 2: squares
    t_dist_ctl          r_s2_ctl;
    logic [IW-1:0]      r_s2_b;
    logic [LIM_W-1:0]   r_s2_qx, r_s2_qy, r_s2_qz;
    // stage 3: compare
    t_dist_rsp          r_s3_rsp;
    logic [IW-1:0]      r_s3_b;

    logic signed [DW-1:0] w_dx, w_dy, w_dz;
    logic [COORD_W-1:0]   w_ax, w_ay, w_az;
    logic [LIM_W+1:0]     w_sum;

    function automatic logic [COORD_W-1:0] f_abs(input logic signed [DW-1:0] d);
        logic signed [DW-1:0] m;
        m = d[DW-1] ? -d : d;
        return m[COORD_W-1:0];
    endfunction

    always_comb begin
        w_dx = DW'(i_b_pt.x) - DW'(i_a_pt.x);
        w_dy = DW'(i_b_pt.y) - DW'(i_a_pt.y);
        w_dz = DW'(i_b_pt.z) - DW'(i_a_pt.z);
        w_ax = f_abs(w_dx);
        w_ay = f_abs(w_dy);
        w_az = f_abs(w_dz);
        w_sum = (LIM_W+2)'(r_s2_qx) + (LIM_W+2)'(r_s2_qy) + (LIM_W+2)'(r_s2_qz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_rsp <= '0;
        end else begin
            r_s1_ctl <= i_req;
            r_s2_ctl <= r_s1_ctl;
            r_s3_rsp.valid <= r_s2_ctl.valid;
            r_s3_rsp.last  <= r_s2_ctl.last;
            r_s3_rsp.hit   <= (w_sum <= (LIM_W+2)'(i_lim));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_b  <= i_b;
        r_s1_dx <= w_ax;
        r_s1_dy <= w_ay;
        r_s1_dz <= w_az;
        r_s2_b  <= r_s1_b;
        r_s2_qx <= r_s1_dx * r_s1_dx;
        r_s2_qy <= r_s1_dy * r_s1_dy;
        r_s2_qz <= r_s1_dz * r_s1_dz;
        r_s3_b  <= r_s2_b;
    end

    assign o_rsp = r_s3_rsp;
    assign o_b   = r_s3_b;

endmodule

FILE: design/first_neighbor_link_finder_top.sv
// Load: one point per cycle, accepted whenever o_busy is low; no result.
// Run: each point a waits for the ring to bring it round, pairs pass a 3-deep pipe, then a rewind.
// Results leave one per strobe cycle and cannot be stalled; the flagged last one strobes as busy falls.
// Reset (i_rst_n low, synchronous) empties the store count, loads register defaults.
// Depends on fnlf_pkg, fnlf_cell, fnlf_dist.
module first_neighbor_link_finder_top #(
    parameter int POINTS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_command,
    input  logic signed [fnlf_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [fnlf_pkg::COORD_W-1:0] i_pos_y,
    input  logic signed [fnlf_pkg::COORD_W-1:0] i_pos_z,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [fnlf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fnlf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // result channel
    output logic                              o_strobe,
    output logic                              o_pair_valid,
    output logic [fnlf_pkg::OUT_IDX_W-1:0]    o_first_index,
    output logic [fnlf_pkg::OUT_IDX_W-1:0]    o_second_index,
    output logic                              o_last_result
);
    import fnlf_pkg::*;

    // IW indexes the ring, CW holds a count up to POINTS
    localparam int IW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CW = $clog2(POINTS + 1);
    localparam int MW = (CW > MAXPT_W) ? CW : MAXPT_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic               r_link_enable;
    logic [MAXPT_W-1:0] r_max_points;
    logic [COORD_W-1:0] r_connect_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_enable      <= 1'b1;
            r_max_points       <= MAX_POINTS_RST;
            r_connect_distance <= CONNECT_DIST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINK_ENABLE:      r_link_enable      <= i_cfg_data[0];
                CFG_MAX_POINTS:       r_max_points       <= i_cfg_data[MAXPT_W-1:0];
                CFG_CONNECT_DISTANCE: r_connect_distance <= i_cfg_data[COORD_W-1:0];
                default: ; // unmapped index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // run state
    // ------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;    // points loaded
    logic [CW-1:0]    r_n, n_n;            // points taking part in this run
    logic [LIM_W-1:0] r_lim, n_lim;        // squared link distance
    logic [IW-1:0]    r_a, n_a;            // current earlier point
    logic             r_have_a, n_have_a;  // point a captured off the ring
    t_point           r_apt, n_apt;
    logic [IW-1:0]    r_h, n_h;            // index of point sitting in cell 0
    logic [OUT_IDX_W-1:0] r_found, n_found;

    // one pair held back so that the final one can carry the last flag
    logic                 r_buf_valid, n_buf_valid;
    logic [OUT_IDX_W-1:0] r_buf_a, n_buf_a;
    logic [OUT_IDX_W-1:0] r_buf_b, n_buf_b;

    logic                 r_strobe, n_strobe;
    logic                 r_pair_valid, n_pair_valid;
    logic [OUT_IDX_W-1:0] r_first, n_first;
    logic [OUT_IDX_W-1:0] r_second, n_second;
    logic                 r_last, n_last;

    logic w_accept, w_do_load, w_do_run, w_rotate, w_done, w_advance, w_pair;
    logic [MW-1:0] w_min;
    logic [CW-1:0] w_h_ext, w_a_ext;

    // ------------------------------------------------------------------
    // point ring: cell i hands its point to cell i-1 while the ring turns
    // ------------------------------------------------------------------
    t_point w_cell_pt [POINTS];
    logic   [POINTS-1:0] w_cell_load;
    t_point w_load_pt;

    assign w_load_pt = '{x: i_pos_x, y: i_pos_y, z: i_pos_z};

    for (genvar gi = 0; gi < POINTS; gi++) begin : g_ring
        assign w_cell_load[gi] = w_do_load && (r_count == CW'(gi));
        fnlf_cell u_cell (
            .i_clk     (i_clk),
            .i_load    (w_cell_load[gi]),
            .i_load_pt (w_load_pt),
            .i_shift   (w_rotate),
            .i_next_pt (w_cell_pt[(gi + 1) % POINTS]),
            .o_pt      (w_cell_pt[gi])
        );
    end

    // ------------------------------------------------------------------
    // distance pipe
    // ------------------------------------------------------------------
    t_dist_ctl     w_req;
    t_dist_rsp     w_rsp;
    logic [IW-1:0] w_rsp_b;
    logic          w_flush;

    fnlf_dist #(
        .IW (IW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (w_flush),
        .i_req   (w_req),
        .i_b     (r_h),
        .i_a_pt  (r_apt),
        .i_b_pt  (w_cell_pt[0]),
        .i_lim   (r_lim),
        .o_rsp   (w_rsp),
        .o_b     (w_rsp_b)
    );

    // ------------------------------------------------------------------
    // shared control terms
    // ------------------------------------------------------------------
    always_comb begin
        w_accept  = i_start && (r_state == ST_IDLE);
        w_do_load = w_accept && !i_command && (r_count < CW'(POINTS));
        w_do_run  = w_accept && i_command;
        w_h_ext   = CW'(r_h);
        w_a_ext   = CW'(r_a);
        // scan finished once no later point is left or the result cap is hit
        w_done    = ((w_a_ext + CW'(1)) >= r_n) || (r_found == RESULT_LIMIT);
        w_rotate  = (r_state == ST_SCAN) || ((r_state == ST_REWIND) && (r_h != '0));
        w_pair    = (r_state == ST_SCAN) && w_rsp.valid && w_rsp.hit;
        w_advance = (r_state == ST_SCAN) && w_rsp.valid && (w_rsp.hit || w_rsp.last);
        w_flush   = w_advance || (r_state != ST_SCAN);
        w_req.valid = (r_state == ST_SCAN) && r_have_a && (w_h_ext > w_a_ext)
                      && (w_h_ext < r_n);
        w_req.last  = (w_h_ext == (r_n - CW'(1)));
        w_min = ((MW'(r_count) < MW'(r_max_points)) ? MW'(r_count) : MW'(r_max_points));
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_do_run) n_state = ST_SCAN;
            ST_SCAN:   if (w_done) n_state = ST_REWIND;
            ST_REWIND: if (r_h == '0) n_state = ST_LAST;
            ST_LAST:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_count     = r_count;
        n_n         = r_n;
        n_lim       = r_lim;
        n_a         = r_a;
        n_have_a    = r_have_a;
        n_apt       = r_apt;
        n_h         = r_h;
        n_found     = r_found;
        n_buf_valid = r_buf_valid;
        n_buf_a     = r_buf_a;
        n_buf_b     = r_buf_b;
        n_strobe     = 1'b0;
        n_pair_valid = 1'b0;
        n_first      = '0;
        n_second     = '0;
        n_last       = 1'b0;

        if (w_do_load) begin
            n_count = r_count + CW'(1);
        end

        if (w_do_run) begin
            n_n         = r_link_enable ? CW'(w_min) : '0;
            n_lim       = LIM_W'(r_connect_distance) * LIM_W'(r_connect_distance);
            n_a         = '0;
            n_have_a    = 1'b0;
            n_found     = '0;
            n_buf_valid = 1'b0;
        end

        if (w_rotate) begin
            n_h = (r_h == IW'(POINTS - 1)) ? '0 : r_h + IW'(1);
        end

        if (r_state == ST_SCAN) begin
            // catch point a as it passes cell 0
            if (!r_have_a && (r_h == r_a)) begin
                n_apt    = w_cell_pt[0];
                n_have_a = 1'b1;
            end
            if (w_pair) begin
                if (r_buf_valid) begin
                    n_strobe     = 1'b1;
                    n_pair_valid = 1'b1;
                    n_first      = r_buf_a;
                    n_second     = r_buf_b;
                end
                n_buf_valid = 1'b1;
                n_buf_a     = OUT_IDX_W'(r_a);
                n_buf_b     = OUT_IDX_W'(w_rsp_b);
                n_found     = r_found + OUT_IDX_W'(1);
            end
            if (w_advance) begin
                n_a      = r_a + IW'(1);
                n_have_a = 1'b0;
            end
        end

        if (r_state == ST_LAST) begin
            n_strobe     = 1'b1;
            n_pair_valid = r_buf_valid;
            n_first      = r_buf_valid ? r_buf_a : '0;
            n_second     = r_buf_valid ? r_buf_b : '0;
            n_last       = 1'b1;
            n_buf_valid  = 1'b0;
            n_count      = '0;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_h         <= '0;
            r_a         <= '0;
            r_have_a    <= 1'b0;
            r_found     <= '0;
            r_buf_valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_h         <= n_h;
            r_a         <= n_a;
            r_have_a    <= n_have_a;
            r_found     <= n_found;
            r_buf_valid <= n_buf_valid;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_lim        <= n_lim;
        r_apt        <= n_apt;
        r_buf_a      <= n_buf_a;
        r_buf_b      <= n_buf_b;
        r_pair_valid <= n_pair_valid;
        r_first      <= n_first;
        r_second     <= n_second;
        r_last       <= n_last;
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_strobe       = r_strobe;
    assign o_pair_valid   = r_pair_valid;
    assign o_first_index  = r_first;
    assign o_second_index = r_second;
    assign o_last_result  = r_last;

endmodule

FILE: bench/tb_first_neighbor_link_finder_top.sv
// Self-checking bench for first_neighbor_link_finder_top: point loads, search runs, registers.
// Depends on fnlf_pkg and the design folder; an in-bench predictor supplies expected links.
module tb_first_neighbor_link_finder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fnlf_pkg::*;

    localparam int POINTS        = 32;
    localparam int SETTLE_CYCLES = 16;     // run tail after its last link, with margin
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 500000;

    localparam bit CMD_LOAD = 1'b0;
    localparam bit CMD_RUN  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // point-cloud shapes used when building a load burst
    typedef enum int {
        CLOUD_CLUSTER,
        CLOUD_SCATTER,
        CLOUD_CORNERS
    } t_cloud;

    typedef struct {
        bit                 pair_valid;
        bit [OUT_IDX_W-1:0] first_index;
        bit [OUT_IDX_W-1:0] second_index;
        bit                 last_result;
    } t_link;

    logic clk = 1'b0;
    logic rst_n;

    logic                        i_start;
    logic                        o_busy;
    logic                        i_command;
    logic signed [COORD_W-1:0]   i_pos_x;
    logic signed [COORD_W-1:0]   i_pos_y;
    logic signed [COORD_W-1:0]   i_pos_z;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;
    logic                        o_strobe;
    logic                        o_pair_valid;
    logic [OUT_IDX_W-1:0]        o_first_index;
    logic [OUT_IDX_W-1:0]        o_second_index;
    logic                        o_last_result;

    // predictor state: own copy of the point store and the registers
    logic signed [COORD_W-1:0] cloud_x [POINTS];
    logic signed [COORD_W-1:0] cloud_y [POINTS];
    logic signed [COORD_W-1:0] cloud_z [POINTS];
    int                        cloud_count = 0;
    bit                        link_on     = 1'b1;
    int                        point_limit = int'(MAX_POINTS_RST);
    bit [COORD_W-1:0]          link_radius = CONNECT_DIST_RST;

    t_link pending_links[$];
    int    mismatch_count = 0;
    int    request_count  = 0;
    int    idle_pct       = 25;
    int    cycle_count    = 0;

    first_neighbor_link_finder_top #(
        .POINTS(POINTS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_command      (i_command),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_pair_valid   (o_pair_valid),
        .o_first_index  (o_first_index),
        .o_second_index (o_second_index),
        .o_last_result  (o_last_result)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop if the block hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Expected links of one request. A load only extends the cloud (ignored when full); a run
    // scans the first min(count, limit) points when linking is on, and always empties the cloud.
    task automatic predict_links(input bit cmd, input logic signed [COORD_W-1:0] x,
                                 input logic signed [COORD_W-1:0] y,
                                 input logic signed [COORD_W-1:0] z);
        int     n;
        bit     hit;
        longint dx, dy, dz, reach;
        t_link  lk;
        t_link  batch[$];
        if (cmd == CMD_LOAD) begin
            if (cloud_count < POINTS) begin
                cloud_x[cloud_count] = x;
                cloud_y[cloud_count] = y;
                cloud_z[cloud_count] = z;
                cloud_count++;
            end
        end else begin
            if (link_on) begin
                n = (cloud_count < point_limit) ? cloud_count : point_limit;
                if (n > POINTS)
                    n = POINTS;
                reach = longint'(link_radius) * longint'(link_radius);
                for (int a = 0; a < n && batch.size() < int'(RESULT_LIMIT); a++) begin
                    hit = 1'b0;
                    for (int b = a + 1; b < n && !hit; b++) begin
                        dx = longint'(cloud_x[a]) - longint'(cloud_x[b]);
                        dy = longint'(cloud_y[a]) - longint'(cloud_y[b]);
                        dz = longint'(cloud_z[a]) - longint'(cloud_z[b]);
                        if (dx * dx + dy * dy + dz * dz <= reach) begin
                            hit             = 1'b1;
                            lk.pair_valid   = 1'b1;
                            lk.first_index  = OUT_IDX_W'(a);
                            lk.second_index = OUT_IDX_W'(b);
                            lk.last_result  = 1'b0;
                            batch.insert(batch.size(), lk);
                        end
                    end
                end
            end
            // nothing linked (or linking off): a single empty result
            if (batch.size() == 0) begin
                lk.pair_valid   = 1'b0;
                lk.first_index  = '0;
                lk.second_index = '0;
                lk.last_result  = 1'b0;
                batch.insert(batch.size(), lk);
            end
            batch[batch.size() - 1].last_result = 1'b1;
            foreach (batch[i])
                pending_links.insert(pending_links.size(), batch[i]);
            cloud_count = 0;
        end
    endtask

    // One request; start stays high on return so back-to-back requests keep it up.
    task automatic send_request(input bit cmd, input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y,
                                input logic signed [COORD_W-1:0] z);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        i_start   <= 1'b1;
        i_command <= cmd;
        i_pos_x   <= x;
        i_pos_y   <= y;
        i_pos_z   <= z;
        @(posedge clk);
        while (o_busy)
            @(posedge clk);
        predict_links(cmd, x, y, z);
        request_count++;
    endtask

    // Drop start, let all links arrive, cover a load-only tail, then see busy low.
    task automatic wait_until_quiet();
        i_start <= 1'b0;
        while (pending_links.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (o_busy)
            @(posedge clk);
    endtask

    // write enable left high; caller lowers it after the last write of a group
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_LINK_ENABLE:      link_on     = data[0];
            CFG_MAX_POINTS:       point_limit = int'(data[MAXPT_W-1:0]);
            CFG_CONNECT_DISTANCE: link_radius = data[COORD_W-1:0];
            default: ;            // unused index: no effect
        endcase
    endtask

    task automatic configure(input bit en, input int max_pts, input int radius);
        wait_until_quiet();
        write_reg(CFG_LINK_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_MAX_POINTS, CFG_DATA_W'(max_pts));
        write_reg(CFG_CONNECT_DISTANCE, CFG_DATA_W'(radius));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] any_coord();
        return COORD_W'($urandom);
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord(input int centre, input int spread);
        return COORD_W'(centre + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic logic signed [COORD_W-1:0] corner_coord();
        case ($urandom_range(0, 3))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    // Burst of loads of one cloud shape, then a run with junk coordinates.
    task automatic load_cloud_then_run(input int n_loads, input t_cloud shape);
        int                        cx, cy, cz, spread;
        logic signed [COORD_W-1:0] px, py, pz;
        cx = int'(any_coord());
        cy = int'(any_coord());
        cz = int'(any_coord());
        // spread tied to the radius so that links and misses both occur
        spread = int'($urandom_range(0, int'(link_radius) / 2 + 2));
        px = any_coord();
        py = any_coord();
        pz = any_coord();
        for (int i = 0; i < n_loads; i++) begin
            case (shape)
                CLOUD_CLUSTER: begin
                    // occasional exact duplicate of the previous point
                    if (i == 0 || $urandom_range(0, 7) != 0) begin
                        px = near_coord(cx, spread);
                        py = near_coord(cy, spread);
                        pz = near_coord(cz, spread);
                    end
                end
                CLOUD_CORNERS: begin
                    px = corner_coord();
                    py = corner_coord();
                    pz = corner_coord();
                end
                default: begin
                    px = any_coord();
                    py = any_coord();
                    pz = any_coord();
                end
            endcase
            send_request(CMD_LOAD, px, py, pz);
        end
        send_request(CMD_RUN, any_coord(), any_coord(), any_coord());
    endtask

    task automatic random_burst();
        int     sel;
        int     n_loads;
        t_cloud shape;
        sel = $urandom_range(0, 99);
        if (sel < 6)
            n_loads = $urandom_range(0, 1);        // empty or single-point runs
        else if (sel < 12)
            n_loads = $urandom_range(30, 36);      // near or past a full store
        else
            n_loads = $urandom_range(2, 12);
        sel = $urandom_range(0, 9);
        shape = (sel < 7) ? CLOUD_CLUSTER : (sel < 9) ? CLOUD_SCATTER : CLOUD_CORNERS;
        load_cloud_then_run(n_loads, shape);
    endtask

    // ---------------------------------------------------------------- tests

    // default registers: exact-threshold link, extreme corners, coincident points
    task automatic test_directed_links();
        send_request(CMD_LOAD, 16'sd0, 16'sd0, 16'sd0);
        send_request(CMD_LOAD, 16'sd100, 16'sd0, 16'sd0);       // exactly on the radius
        send_request(CMD_LOAD, -16'sd32768, -16'sd32768, -16'sd32768);
        send_request(CMD_LOAD, 16'sd32767, 16'sd32767, 16'sd32767);
        send_request(CMD_LOAD, -16'sd32768, -16'sd32768, -16'sd32768);
        send_request(CMD_LOAD, 16'sd0, -16'sd100, 16'sd1);      // just outside
        send_request(CMD_RUN, 16'sd32767, -16'sd32768, -16'sd1);
    endtask

    // run with nothing loaded, then with a single point
    task automatic test_directed_sparse_runs();
        send_request(CMD_RUN, 16'sd0, 16'sd0, 16'sd0);
        send_request(CMD_LOAD, 16'sd7, -16'sd7, 16'sd7);
        send_request(CMD_RUN, -16'sd1, -16'sd1, -16'sd1);
    endtask

    // write to the unused index must change nothing; zero radius links only coincident points
    task automatic test_directed_zero_radius();
        wait_until_quiet();
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(CFG_CONNECT_DISTANCE, '0);
        i_cfg_we <= 1'b0;
        send_request(CMD_LOAD, 16'sd5, 16'sd5, 16'sd5);
        send_request(CMD_LOAD, 16'sd6, 16'sd5, 16'sd5);
        send_request(CMD_LOAD, 16'sd5, 16'sd5, 16'sd5);
        send_request(CMD_RUN, 16'sd0, 16'sd0, 16'sd0);
    endtask

    task automatic test_directed_link_disabled();
        configure(1'b0, POINTS, 100);
        send_request(CMD_LOAD, 16'sd3, 16'sd3, 16'sd3);
        send_request(CMD_LOAD, 16'sd3, 16'sd3, 16'sd3);
        send_request(CMD_RUN, 16'sd0, 16'sd0, 16'sd0);
    endtask

    // only the first two points take part, so the close third one is cut off
    task automatic test_directed_point_limit();
        configure(1'b1, 2, 100);
        send_request(CMD_LOAD, 16'sd0, 16'sd0, 16'sd0);
        send_request(CMD_LOAD, 16'sd1000, 16'sd0, 16'sd0);
        send_request(CMD_LOAD, 16'sd0, 16'sd0, 16'sd1);
        send_request(CMD_RUN, 16'sd0, 16'sd0, 16'sd0);
    endtask

    // loads past capacity are dropped
    task automatic test_store_full();
        configure(1'b1, POINTS, 4000);
        load_cloud_then_run(36, CLOUD_CLUSTER);
    endtask

    // register sweeps: extremes first, then random settings
    task automatic test_random_mix();
        int phase_start;
        int radius;
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: configure(1'b1, POINTS, 65535);
                1: configure(1'b1, 0, 300);
                2: configure(1'b1, 1, 300);
                3: configure(1'b0, POINTS, 2000);
                4: configure(1'b1, POINTS, 0);
                default: begin
                    radius = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                                         : int'($urandom_range(0, 3000));
                    configure($urandom_range(0, 7) != 0, $urandom_range(0, POINTS), radius);
                end
            endcase
            idle_pct = (phase % 3 == 2) ? 0 : 30;
            phase_start = request_count;
            while (request_count - phase_start < 13)
                random_burst();
        end
    endtask

    // closing stretch: no gaps between requests
    task automatic test_back_to_back();
        int start_count;
        configure(1'b1, POINTS, 1500);
        idle_pct = 0;
        start_count = request_count;
        while (request_count - start_count < 20)
            random_burst();
    endtask

    // each strobe must match the oldest expected link
    always @(posedge clk) begin : check_links
        t_link want;
        if (rst_n && o_strobe) begin
            if (pending_links.size() == 0) begin
                report_mismatch("unexpected result, pair_valid", o_pair_valid, 0);
            end else begin
                want = pending_links.pop_front();
                if (o_pair_valid !== want.pair_valid)
                    report_mismatch("pair_valid", o_pair_valid, want.pair_valid);
                if (o_first_index !== want.first_index)
                    report_mismatch("first_index", o_first_index, want.first_index);
                if (o_second_index !== want.second_index)
                    report_mismatch("second_index", o_second_index, want.second_index);
                if (o_last_result !== want.last_result)
                    report_mismatch("last_result", o_last_result, want.last_result);
            end
        end
    end

    initial begin
        rst_n       <= 1'b0;
        i_start     <= 1'b0;
        i_command   <= CMD_LOAD;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_pos_z     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_LINK_ENABLE;
        i_cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_links();
        test_directed_sparse_runs();
        test_directed_zero_radius();
        test_directed_link_disabled();
        test_directed_point_limit();
        test_store_full();
        test_random_mix();
        test_back_to_back();

        wait_until_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_links.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/fnlf_pkg.sv
design/fnlf_cell.sv
design/fnlf_dist.sv
design/first_neighbor_link_finder_top.sv
bench/tb_first_neighbor_link_finder_top.sv
